/* rtl/fncs_pkg.sv */
`default_nettype none
package fncs_pkg;

   localparam int FOCUS_W      = 22;
   localparam int DIV_W        = FOCUS_W - 1;
   localparam int CHUNK_IDX_W  = 10;
   localparam int COUNT_W      = 11;
   localparam int FPC_W        = 16;
   localparam int STATE_W      = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam int MAX_CHUNKS_DEF = 1024;

   localparam logic [FPC_W-1:0]   FPC_RST        = 16'd1;
   localparam logic [COUNT_W-1:0] NEAR_REACH_RST = 11'd12;

   localparam logic [CSR_IDX_W-1:0] CSR_FPC   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHOLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REACH = 2'd3;

   localparam logic ACT_PICK = 1'b0;
   localparam logic ACT_MARK = 1'b1;

   localparam logic [STATE_W-1:0] ST_MISSING  = 2'd0;
   localparam logic [STATE_W-1:0] ST_WORKING  = 2'd1;
   localparam logic [STATE_W-1:0] ST_READY    = 2'd2;
   localparam logic [STATE_W-1:0] ST_RESERVED = 2'd3;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_stat_type;

endpackage
`default_nettype wire

/* rtl/fncs_ram.sv */
`default_nettype none
module fncs_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/fncs_div.sv */
`default_nettype none
module fncs_div
   import fncs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [FPC_W-1:0] divisor,
   output div_stat_type          stat
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [FPC_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;

   logic [FPC_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      ge      = rem_sh >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? FPC_W'(rem_sh - {1'b0, divisor}) : rem_sh[FPC_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.done = done_ff;
   assign stat.quot = quo_ff;

endmodule
`default_nettype wire

/* rtl/focus_nearest_chunk_scheduler.sv */
// Mark: the request passes through the mark and done states before the result enters the output register.
// Pick: the 21-step divider and setup run, then each table entry examined takes a read
//   state and a check state (up to 2 * (reach + 1) entries); a side outside the table skips its check.
// One request in flight; the next is taken once its result is in the output register.
// Reset (synchronous): control and CSR registers take their reset values, then a
//   clearing pass sets every entry missing with req_stall high.
`default_nettype none
module focus_nearest_chunk_scheduler
   import fncs_pkg::*;
#(
   parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_action,
   input  wire logic signed [FOCUS_W-1:0] req_focus_frame,
   input  wire logic [CHUNK_IDX_W-1:0] req_chunk_index,
   input  wire logic [STATE_W-1:0]     req_new_state,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_found,
   output logic [CHUNK_IDX_W-1:0]      rsp_picked_chunk,
   output logic                        rsp_mark_applied
);

   localparam int ADDR_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int POS_W  = COUNT_W + 1;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_SETUP = 4'd3;
   localparam logic [3:0] S_UPRD  = 4'd4;
   localparam logic [3:0] S_UPCK  = 4'd5;
   localparam logic [3:0] S_DNRD  = 4'd6;
   localparam logic [3:0] S_DNCK  = 4'd7;
   localparam logic [3:0] S_MARK  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [FPC_W-1:0]   fpc_ff, fpc_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               whole_ff, whole_in;
   logic [COUNT_W-1:0] nreach_ff, nreach_in;

   logic [3:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               neg_ff, neg_in;
   logic [CHUNK_IDX_W-1:0] idx_ff, idx_in;
   logic [STATE_W-1:0] nst_ff, nst_in;
   logic [COUNT_W-1:0] cen_ff, cen_in;
   logic [COUNT_W-1:0] reach_ff, reach_in;
   logic [POS_W-1:0]   dist_ff, dist_in;
   logic               res_found_ff, res_found_in;
   logic [CHUNK_IDX_W-1:0] res_pick_ff, res_pick_in;
   logic               res_mark_ff, res_mark_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [CHUNK_IDX_W-1:0] rsp_pick_ff, rsp_pick_in;
   logic               rsp_mark_ff, rsp_mark_in;

   logic               req_xfer;
   logic [COUNT_W-1:0] total;
   logic [COUNT_W-1:0] reach_sel;
   logic [FPC_W-1:0]   per;
   logic [POS_W-1:0]   up_pos, dn_pos;
   logic               up_ok, dn_ok, last_dist, mark_ok, hit, out_free;
   logic [ADDR_W+POS_W-1:0]       up_ext, dn_ext;
   logic [ADDR_W+CHUNK_IDX_W-1:0] idx_ext;
   logic [ADDR_W-1:0]  up_addr, dn_addr, idx_addr;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [STATE_W-1:0] wr_data, rd_data;
   div_stat_type       div_stat;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign per       = (fpc_ff == '0) ? FPC_W'(1) : fpc_ff;

   always_comb begin
      if (32'(cnt_ff) > MAX_CHUNKS) begin
         total = COUNT_W'(MAX_CHUNKS);
      end else begin
         total = cnt_ff;
      end
      reach_sel = whole_ff ? total : nreach_ff;
      if (reach_sel > total) begin
         reach_sel = total;
      end
   end

   assign up_pos    = {1'b0, cen_ff} + dist_ff;
   assign dn_pos    = {1'b0, cen_ff} - dist_ff;
   assign up_ok     = up_pos < {1'b0, total};
   assign dn_ok     = dist_ff <= {1'b0, cen_ff};
   assign last_dist = dist_ff == {1'b0, reach_ff};
   assign mark_ok   = {1'b0, idx_ff} < total;
   assign hit       = rd_data == ST_MISSING;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign up_ext   = {{ADDR_W{1'b0}}, up_pos};
   assign dn_ext   = {{ADDR_W{1'b0}}, dn_pos};
   assign idx_ext  = {{ADDR_W{1'b0}}, idx_ff};
   assign up_addr  = up_ext[ADDR_W-1:0];
   assign dn_addr  = dn_ext[ADDR_W-1:0];
   assign idx_addr = idx_ext[ADDR_W-1:0];

   always_comb begin
      fpc_in    = fpc_ff;
      cnt_in    = cnt_ff;
      whole_in  = whole_ff;
      nreach_in = nreach_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FPC:   fpc_in    = csr_wdata;
            CSR_COUNT: cnt_in    = csr_wdata[COUNT_W-1:0];
            CSR_WHOLE: whole_in  = csr_wdata[0];
            CSR_REACH: nreach_in = csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      neg_in       = neg_ff;
      idx_in       = idx_ff;
      nst_in       = nst_ff;
      cen_in       = cen_ff;
      reach_in     = reach_ff;
      dist_in      = dist_ff;
      res_found_in = res_found_ff;
      res_pick_in  = res_pick_ff;
      res_mark_in  = res_mark_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_pick_in  = rsp_pick_ff;
      rsp_mark_in  = rsp_mark_ff;
      wr_en        = 1'b0;
      wr_addr      = up_addr;
      wr_data      = ST_WORKING;
      rd_addr      = up_addr;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = ST_MISSING;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MAX_CHUNKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               neg_in       = req_focus_frame[FOCUS_W-1];
               idx_in       = req_chunk_index;
               nst_in       = req_new_state;
               res_found_in = 1'b0;
               res_pick_in  = '0;
               res_mark_in  = 1'b0;
               state_in     = (req_action == ACT_MARK) ? S_MARK : S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            dist_in  = '0;
            reach_in = reach_sel;
            if (neg_ff) begin
               cen_in = '0;
            end else if (div_stat.quot >= DIV_W'(total)) begin
               cen_in = total - COUNT_W'(1);
            end else begin
               cen_in = div_stat.quot[COUNT_W-1:0];
            end
            state_in = (total == '0) ? S_DONE : S_UPRD;
         end
         S_UPRD: begin
            rd_addr  = up_addr;
            state_in = up_ok ? S_UPCK : S_DNRD;
         end
         S_UPCK: begin
            if (hit) begin
               wr_en        = 1'b1;
               wr_addr      = up_addr;
               res_found_in = 1'b1;
               res_pick_in  = up_pos[CHUNK_IDX_W-1:0];
               state_in     = S_DONE;
            end else begin
               state_in = S_DNRD;
            end
         end
         S_DNRD: begin
            rd_addr = dn_addr;
            if (dn_ok) begin
               state_in = S_DNCK;
            end else if (last_dist) begin
               state_in = S_DONE;
            end else begin
               dist_in  = dist_ff + POS_W'(1);
               state_in = S_UPRD;
            end
         end
         S_DNCK: begin
            if (hit) begin
               wr_en        = 1'b1;
               wr_addr      = dn_addr;
               res_found_in = 1'b1;
               res_pick_in  = dn_pos[CHUNK_IDX_W-1:0];
               state_in     = S_DONE;
            end else if (last_dist) begin
               state_in = S_DONE;
            end else begin
               dist_in  = dist_ff + POS_W'(1);
               state_in = S_UPRD;
            end
         end
         S_MARK: begin
            wr_en       = mark_ok;
            wr_addr     = idx_addr;
            wr_data     = nst_ff;
            res_mark_in = mark_ok;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pick_in  = res_pick_ff;
               rsp_mark_in  = res_mark_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fpc_ff       <= FPC_RST;
         cnt_ff       <= '0;
         whole_ff     <= 1'b0;
         nreach_ff    <= NEAR_REACH_RST;
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fpc_ff       <= fpc_in;
         cnt_ff       <= cnt_in;
         whole_ff     <= whole_in;
         nreach_ff    <= nreach_in;
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff       <= neg_in;
      idx_ff       <= idx_in;
      nst_ff       <= nst_in;
      cen_ff       <= cen_in;
      reach_ff     <= reach_in;
      dist_ff      <= dist_in;
      res_found_ff <= res_found_in;
      res_pick_ff  <= res_pick_in;
      res_mark_ff  <= res_mark_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pick_ff  <= rsp_pick_in;
      rsp_mark_ff  <= rsp_mark_in;
   end

   fncs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_xfer && (req_action == ACT_PICK)),
      .dividend (req_focus_frame[DIV_W-1:0]),
      .divisor  (per),
      .stat     (div_stat)
   );

   fncs_ram #(
      .WIDTH (STATE_W),
      .DEPTH (MAX_CHUNKS)
   ) u_states (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_picked_chunk = rsp_pick_ff;
   assign rsp_mark_applied = rsp_mark_ff;

endmodule
`default_nettype wire

/* rtl/fncs_chk.sv */
`default_nettype none
module fncs_chk
   import fncs_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic                   rsp_found,
   input wire logic [CHUNK_IDX_W-1:0] rsp_picked_chunk,
   input wire logic                   rsp_mark_applied
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_picked_chunk) && $stable(rsp_mark_applied))
      else $error("stalled transfer changed");

   a_no_pick_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_picked_chunk == '0)
      else $error("picked chunk nonzero without a claim");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mark_applied |-> !rsp_found)
      else $error("mark and pick result together");

   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("request taken or result shown during table clear");

endmodule

bind focus_nearest_chunk_scheduler fncs_chk u_chk (.*);
`default_nettype wire

/* tb/focus_nearest_chunk_scheduler_tb.sv */
`timescale 1ns / 100ps
module focus_nearest_chunk_scheduler_tb;
   import fncs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 10_000_000;

   typedef struct packed {
      logic                   action;
      logic [FOCUS_W-1:0]     focus;
      logic [CHUNK_IDX_W-1:0] index;
      logic [STATE_W-1:0]     state;
   } sched_req_type;

   typedef struct packed {
      logic                   found;
      logic [CHUNK_IDX_W-1:0] chunk;
      logic                   applied;
   } sched_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_action = ACT_PICK;
   logic signed [FOCUS_W-1:0]     req_focus_frame = '0;
   logic [CHUNK_IDX_W-1:0]        req_chunk_index = '0;
   logic [STATE_W-1:0]            req_new_state = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_found;
   logic [CHUNK_IDX_W-1:0]        rsp_picked_chunk;
   logic                          rsp_mark_applied;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned cycle_count = 0;

   class chunk_table_model_type;
      logic [FPC_W-1:0]   fpc;
      logic [COUNT_W-1:0] count;
      logic               whole;
      logic [COUNT_W-1:0] reach;
      logic [STATE_W-1:0] states [MAX_CHUNKS_DEF];
      sched_rsp_type      pending_rsp[$];
      int                 errors;

      function new();
         fpc = FPC_RST;
         count = '0;
         whole = 1'b0;
         reach = NEAR_REACH_RST;
         errors = 0;
         foreach (states[i]) states[i] = ST_MISSING;
      endfunction

      function int unsigned used_chunks();
         return (count > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF : count;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FPC:   fpc = data[FPC_W-1:0];
            CSR_COUNT: count = data[COUNT_W-1:0];
            CSR_WHOLE: whole = data[0];
            CSR_REACH: reach = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // claim the nearest missing chunk (later side first) or apply a mark
      function sched_rsp_type claim_or_mark(sched_req_type r);
         sched_rsp_type e;
         int unsigned   total, per, centre, span, d, idx;
         e = '0;
         total = used_chunks();
         if (r.action == ACT_MARK) begin
            if (r.index < total) begin
               states[r.index] = r.state;
               e.applied = 1'b1;
            end
         end else if (total != 0) begin
            per = (fpc == 0) ? 1 : fpc;
            centre = r.focus[FOCUS_W-1] ? 0 : r.focus[DIV_W-1:0] / per;
            if (centre >= total) centre = total - 1;
            span = whole ? total : reach;
            if (span > total) span = total;
            for (d = 0; d <= span && !e.found; d++) begin
               idx = centre + d;
               if (idx < total && states[idx] == ST_MISSING) begin
                  e.found = 1'b1;
               end else if (d <= centre && states[centre - d] == ST_MISSING) begin
                  idx = centre - d;
                  e.found = 1'b1;
               end
               if (e.found) begin
                  states[idx] = ST_WORKING;
                  e.chunk = idx[CHUNK_IDX_W-1:0];
               end
            end
         end
         return e;
      endfunction

      function void note_request(sched_req_type r);
         sched_rsp_type e;
         e = claim_or_mark(r);
         pending_rsp = {pending_rsp, e};
      endfunction

      function void check_response(logic found, logic [CHUNK_IDX_W-1:0] chunk, logic applied);
         sched_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("response with nothing pending: found %0d chunk %0d mark_applied %0d",
                   found, chunk, applied);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (found !== e.found) begin
            $error("found: expected %0d, actual %0d", e.found, found);
            errors++;
         end
         if (chunk !== e.chunk) begin
            $error("picked_chunk: expected %0d, actual %0d", e.chunk, chunk);
            errors++;
         end
         if (applied !== e.applied) begin
            $error("mark_applied: expected %0d, actual %0d", e.applied, applied);
            errors++;
         end
      endfunction
   endclass

   chunk_table_model_type model = new();

   focus_nearest_chunk_scheduler u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_focus_frame  (req_focus_frame),
      .req_chunk_index  (req_chunk_index),
      .req_new_state    (req_new_state),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_picked_chunk (rsp_picked_chunk),
      .rsp_mark_applied (rsp_mark_applied)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         model.check_response(rsp_found, rsp_picked_chunk, rsp_mark_applied);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(input sched_req_type r);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_action      <= r.action;
      req_focus_frame <= r.focus;
      req_chunk_index <= r.index;
      req_new_state   <= r.state;
      do @(posedge clock); while (req_stall);
      model.note_request(r);
   endtask

   task automatic send_pick(input int focus);
      sched_req_type r;
      r.action = ACT_PICK;
      r.focus = focus[FOCUS_W-1:0];
      r.index = CHUNK_IDX_W'($urandom);
      r.state = STATE_W'($urandom);
      send_request(r);
   endtask

   task automatic send_mark(input int unsigned index, input logic [STATE_W-1:0] state);
      sched_req_type r;
      r.action = ACT_MARK;
      r.focus = FOCUS_W'($urandom);
      r.index = index[CHUNK_IDX_W-1:0];
      r.state = state;
      send_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (model.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(input logic [FPC_W-1:0] fpc, input logic [COUNT_W-1:0] count,
                               input logic whole, input logic [COUNT_W-1:0] reach);
      logic [CSR_IDX_W-1:0]  regs [4];
      logic [CSR_DATA_W-1:0] vals [4];
      regs = '{CSR_FPC, CSR_COUNT, CSR_WHOLE, CSR_REACH};
      vals = '{fpc, CSR_DATA_W'(count), CSR_DATA_W'(whole), CSR_DATA_W'(reach)};
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         model.write_reg(regs[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic sched_req_type random_request();
      sched_req_type r;
      int unsigned   used, per, frame;
      used = model.used_chunks();
      per = (model.fpc == 0) ? 1 : model.fpc;
      r.action = ($urandom_range(99) < 40) ? ACT_MARK : ACT_PICK;
      r.focus = FOCUS_W'($urandom);
      r.index = CHUNK_IDX_W'($urandom);
      r.state = STATE_W'($urandom);
      if (r.action == ACT_MARK) begin
         if (used != 0 && $urandom_range(99) < 85) begin
            r.index = CHUNK_IDX_W'($urandom_range(used - 1));
         end
         if ($urandom_range(1)) r.state = ST_MISSING;
      end else begin
         case ($urandom_range(9))
            0: r.focus[FOCUS_W-1] = 1'b1;
            1: ;
            default: begin
               frame = $urandom_range(used + 1) * per + $urandom_range(per - 1);
               r.focus = frame[FOCUS_W-1:0];
               r.focus[FOCUS_W-1] = 1'b0;
            end
         endcase
      end
      return r;
   endfunction

   task automatic run_phase(input logic [FPC_W-1:0] fpc, input logic [COUNT_W-1:0] count,
                            input logic whole, input logic [COUNT_W-1:0] reach,
                            input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned items);
      write_config(fpc, count, whole, reach);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int unsigned n = 0; n < items; n++) begin
         send_request(random_request());
         if ($urandom_range(63) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: window edges, clamping, range checks, state code three
      write_config(16'd4, 11'd16, 1'b0, 11'd2);
      send_pick(0);
      send_pick(0);
      send_pick(-2097152);
      send_pick(2097151);
      send_pick(63);
      send_mark(15, ST_RESERVED);
      send_mark(16, ST_WORKING);
      send_mark(1023, ST_READY);
      send_mark(0, ST_MISSING);
      send_mark(1, ST_READY);
      send_pick(0);
      send_pick(0);
      send_pick(60);
      send_pick(9);
      // empty table, zero frames per chunk
      write_config(16'd0, 11'd0, 1'b1, 11'd0);
      send_pick(100);
      send_mark(0, ST_WORKING);
      send_pick(-1);
      // count beyond the store
      write_config(16'hFFFF, 11'd2047, 1'b0, 11'd0);
      send_pick(2097151);
      send_pick(0);
      send_mark(1023, ST_MISSING);
      send_mark(1023, ST_RESERVED);
      // whole mode with oversized reach
      write_config(16'd1, 11'd20, 1'b1, 11'd2047);
      send_pick(10);
      send_pick(10);
      send_pick(2097151);

      run_phase(16'd1,     11'd64,   1'b0, 11'd12,   0,  0,  250);
      run_phase(16'd0,     11'd200,  1'b0, 11'd0,    61, 0,  200);
      run_phase(16'hFFFF,  11'd100,  1'b0, 11'd1024, 0,  61, 200);
      run_phase(16'd7,     11'd1024, 1'b0, 11'd5,    20, 20, 250);
      run_phase(16'd3,     11'd2047, 1'b0, 11'd20,   0,  0,  150);
      run_phase(16'd1000,  11'd1024, 1'b1, 11'd2047, 61, 0,  40);
      run_phase(16'd1,     11'd0,    1'b1, 11'd12,   0,  61, 30);
      run_phase(16'd1,     11'd300,  1'b1, 11'd3,    20, 20, 150);
      run_phase(16'hFFFF,  11'd1,    1'b0, 11'd0,    0,  0,  30);

      wait_drained();
      rsp_stall_pct = 0;
      repeat (40) @(posedge clock);
      if (model.errors == 0 && model.pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
